>>> sv/fraction_reduce_gcd_assert.svh
// assertion macros shared by the fraction reduction blocks
`ifndef FRACTION_REDUCE_GCD_ASSERT_SVH
`define FRACTION_REDUCE_GCD_ASSERT_SVH

// property that holds at every clock edge outside reset
`define FRGCD_ASSERT_HOLDS(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("frgcd: check failed");

// condition in one cycle implies a consequence in the next
`define FRGCD_ASSERT_NEXT(lbl, ck, rn, trig, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cons)) \
        else $error("frgcd: sequence check failed");

`endif

>>> sv/frgcd_pkg.sv
package frgcd_pkg;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> sv/frgcd_in_if.sv
interface frgcd_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] numer_in;
    logic signed [WORD_BITS-1:0] denom_in;

    modport source (output valid, output numer_in, output denom_in, input ready);
    modport sink (input valid, input numer_in, input denom_in, output ready);
endinterface

>>> sv/frgcd_out_if.sv
interface frgcd_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] numer_out;
    logic signed [WORD_BITS-1:0] denom_out;

    modport source (output valid, output numer_out, output denom_out, input ready);
    modport sink (input valid, input numer_out, input denom_out, output ready);
endinterface

>>> sv/frgcd_front.sv
module frgcd_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    frgcd_in_if.sink                 feed,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [2*WORD_BITS+1:0]   q_data
);

    typedef struct packed {
        logic                 pass;
        logic                 neg;
        logic [WORD_BITS-1:0] numer;
        logic [WORD_BITS-1:0] denom;
    } entry_t;

    logic                 fe_valid_reg;
    entry_t               fe_data_reg;
    entry_t               fe_data_next;
    logic [WORD_BITS-1:0] n_bits;
    logic [WORD_BITS-1:0] d_bits;
    logic                 take;

    assign n_bits = WORD_BITS'(feed.numer_in);
    assign d_bits = WORD_BITS'(feed.denom_in);

    assign q_push     = fe_valid_reg && !q_full;
    assign feed.ready = !fe_valid_reg || !q_full;
    assign take       = feed.valid && feed.ready;
    assign q_data     = fe_data_reg;

    // negative or at most one: no reduction
    always_comb
    begin
        fe_data_next.pass  = d_bits[WORD_BITS-1] || (d_bits[WORD_BITS-1:1] == '0);
        fe_data_next.neg   = n_bits[WORD_BITS-1];
        fe_data_next.denom = d_bits;
        if (!fe_data_next.pass && n_bits[WORD_BITS-1])
        begin
            fe_data_next.numer = ~n_bits + WORD_BITS'(1);
        end
        else
        begin
            fe_data_next.numer = n_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            fe_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            fe_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fe_data_reg <= fe_data_next;
        end
    end

endmodule

>>> sv/frgcd_queue.sv
module frgcd_queue #(
    parameter int ENTRY_BITS = 66
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ENTRY_BITS-1:0] push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output logic [ENTRY_BITS-1:0] pop_data
);

    import frgcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_BITS-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/frgcd_divider.sv
`include "fraction_reduce_gcd_assert.svh"

module frgcd_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WORD_BITS-1:0]   dividend,
    input  logic [WORD_BITS-1:0]   divisor,
    output frgcd_pkg::div_stat_t   stat,
    output logic [WORD_BITS-1:0]   quotient,
    output logic [WORD_BITS-1:0]   remainder
);

    import frgcd_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] dsr_reg;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] quo_next;
    logic [WORD_BITS:0]   rem_shift;
    logic [WORD_BITS:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WORD_BITS-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        rem_next  = diff[WORD_BITS] ? rem_shift[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
        quo_next  = {quo_reg[WORD_BITS-2:0], ~diff[WORD_BITS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `FRGCD_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg && !done_reg)

endmodule

>>> sv/frgcd_back.sv
`include "fraction_reduce_gcd_assert.svh"

module frgcd_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [2*WORD_BITS+1:0] q_data,
    output logic                   q_pop,
    output logic                   div_start,
    output logic [WORD_BITS-1:0]   div_dividend,
    output logic [WORD_BITS-1:0]   div_divisor,
    input  frgcd_pkg::div_stat_t   div_stat,
    input  logic [WORD_BITS-1:0]   div_quotient,
    input  logic [WORD_BITS-1:0]   div_remainder,
    frgcd_out_if.source            result
);

    import frgcd_pkg::*;

    typedef struct packed {
        logic                 pass;
        logic                 neg;
        logic [WORD_BITS-1:0] numer;
        logic [WORD_BITS-1:0] denom;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_NUM,
        ST_DEN,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    entry_t               head;
    logic                 start_reg;
    logic [WORD_BITS-1:0] op_a_reg;
    logic [WORD_BITS-1:0] op_b_reg;
    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] denom_reg;
    logic                 neg_reg;
    logic [WORD_BITS-1:0] num_q_reg;
    logic [WORD_BITS-1:0] res_numer_reg;
    logic [WORD_BITS-1:0] res_denom_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_numer_reg;
    logic [WORD_BITS-1:0] out_denom_reg;
    logic                 div_phase;
    logic                 out_stall;

    assign head         = q_data;
    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign div_start    = start_reg;
    assign div_dividend = op_a_reg;
    assign div_divisor  = op_b_reg;

    assign result.valid     = out_valid_reg;
    assign result.numer_out = out_numer_reg;
    assign result.denom_out = out_denom_reg;

    assign div_phase = (state_reg == ST_GCD) || (state_reg == ST_NUM) ||
                       (state_reg == ST_DEN);
    assign out_stall = out_valid_reg && !result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            op_a_reg      <= '0;
            op_b_reg      <= '0;
            mag_reg       <= '0;
            denom_reg     <= '0;
            neg_reg       <= 1'b0;
            num_q_reg     <= '0;
            res_numer_reg <= '0;
            res_denom_reg <= '0;
            out_valid_reg <= 1'b0;
            out_numer_reg <= '0;
            out_denom_reg <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        mag_reg   <= head.numer;
                        denom_reg <= head.denom;
                        neg_reg   <= head.neg;
                        if (head.pass)
                        begin
                            res_numer_reg <= head.numer;
                            res_denom_reg <= head.denom;
                            state_reg     <= ST_FINISH;
                        end
                        else
                        begin
                            op_a_reg  <= head.numer;
                            op_b_reg  <= head.denom;
                            start_reg <= 1'b1;
                            state_reg <= ST_GCD;
                        end
                    end
                end
                ST_GCD:
                begin
                    if (div_stat.done)
                    begin
                        start_reg <= 1'b1;
                        if (div_remainder == '0)
                        begin
                            // op_b holds the gcd
                            op_a_reg  <= mag_reg;
                            state_reg <= ST_NUM;
                        end
                        else
                        begin
                            op_a_reg <= op_b_reg;
                            op_b_reg <= div_remainder;
                        end
                    end
                end
                ST_NUM:
                begin
                    if (div_stat.done)
                    begin
                        num_q_reg <= div_quotient;
                        op_a_reg  <= denom_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN:
                begin
                    if (div_stat.done)
                    begin
                        res_numer_reg <= neg_reg ? (~num_q_reg + WORD_BITS'(1)) : num_q_reg;
                        res_denom_reg <= div_quotient;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // wait until the output register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_numer_reg <= res_numer_reg;
                        out_denom_reg <= res_denom_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `FRGCD_ASSERT_HOLDS(a_start_free, clk, rst_n, start_reg |-> !div_stat.busy)
    `FRGCD_ASSERT_HOLDS(a_done_state, clk, rst_n, div_stat.done |-> div_phase)
    `FRGCD_ASSERT_NEXT(a_hold_result, clk, rst_n, out_stall, out_valid_reg)
    `FRGCD_ASSERT_NEXT(a_hold_data, clk, rst_n, out_stall, $stable(out_numer_reg))

endmodule

>>> sv/fraction_reduce_gcd.sv
// channel   role    payload                 handshake
// feed      sink    numer_in, denom_in      valid / ready
// result    source  numer_out, denom_out    valid / ready
//
// pass-through items (denominator at most one) skip the divider
// reduced items run k euclid remainder steps, then divide numerator and denominator by the gcd
// the shared restoring divider, one quotient bit per cycle, sets the pace
// a front register and a 2-entry queue keep accepting while the back part works
// a finished result waits in the output register while the next item starts
// reset clears control and the back part's registers; no clearing pass
module fraction_reduce_gcd #(
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    frgcd_in_if.sink    feed,
    frgcd_out_if.source result
);

    import frgcd_pkg::*;

    localparam int ENTRY_BITS = 2 * WORD_BITS + 2;

    logic                  q_push;
    logic                  q_full;
    logic [ENTRY_BITS-1:0] q_in_data;
    logic                  q_pop;
    logic                  q_valid;
    logic [ENTRY_BITS-1:0] q_out_data;
    logic                  div_start;
    logic [WORD_BITS-1:0]  div_dividend;
    logic [WORD_BITS-1:0]  div_divisor;
    div_stat_t             div_stat;
    logic [WORD_BITS-1:0]  div_quotient;
    logic [WORD_BITS-1:0]  div_remainder;

    frgcd_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in_data)
    );

    frgcd_queue #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out_data)
    );

    frgcd_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    frgcd_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_out_data),
        .q_pop         (q_pop),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_stat      (div_stat),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .result        (result)
    );

endmodule

>>> tb/sv/fraction_reduce_gcd_tb.sv
`timescale 1ns / 1ps

module fraction_reduce_gcd_tb;

    localparam int WORD_BITS = 32;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned DRAIN_CYCLES = 64;

    localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MOST_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic [WORD_BITS-1:0] numer;
        logic [WORD_BITS-1:0] denom;
    } fraction_t;

    logic clk = 1'b0;
    logic rst_n;

    frgcd_in_if  #(.WORD_BITS(WORD_BITS)) feed_if ();
    frgcd_out_if #(.WORD_BITS(WORD_BITS)) result_if ();

    fraction_reduce_gcd #(.WORD_BITS(WORD_BITS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if)
    );

    fraction_t   pending_terms[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned ready_run = 0;
    int unsigned ready_mode = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // euclid on the magnitude, sign taken from the numerator's top bit
    function automatic fraction_t lowest_terms(logic [WORD_BITS-1:0] n,
                                               logic [WORD_BITS-1:0] d);
        fraction_t            r;
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] q;
        if (!d[WORD_BITS-1] && d > 1)
        begin
            mag = n[WORD_BITS-1] ? -n : n;
            x = mag;
            y = d;
            while (y != 0)
            begin
                rem = x % y;
                x = y;
                y = rem;
            end
            q = mag / x;
            r.numer = n[WORD_BITS-1] ? -q : q;
            r.denom = d / x;
        end
        else
        begin
            r.numer = n;
            r.denom = d;
        end
        return r;
    endfunction

    task automatic send_fraction(logic [WORD_BITS-1:0] n, logic [WORD_BITS-1:0] d);
        feed_if.valid    <= 1'b1;
        feed_if.numer_in <= n;
        feed_if.denom_in <= d;
        do
            @(posedge clk);
        while (!(feed_if.valid && feed_if.ready));
        pending_terms.push_back(lowest_terms(n, d));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            feed_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // receiver: runs of always-ready, coin-flip, and mostly-stalled
    always @(posedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (ready_run == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                ready_run = $urandom_range(8, 200);
            end
            else
                ready_run--;
            case (ready_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= $urandom_range(0, 1);
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_terms.size() == 0)
            begin
                $error("unexpected transaction: numer_out %0d, denom_out %0d",
                       $signed(result_if.numer_out), $signed(result_if.denom_out));
                mismatch_count++;
            end
            else
            begin
                want = pending_terms.pop_front();
                if (result_if.numer_out !== want.numer)
                begin
                    $error("numer_out mismatch: expected %0d, actual %0d",
                           $signed(want.numer), $signed(result_if.numer_out));
                    mismatch_count++;
                end
                if (result_if.denom_out !== want.denom)
                begin
                    $error("denom_out mismatch: expected %0d, actual %0d",
                           $signed(want.denom), $signed(result_if.denom_out));
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_zero_numerator();
        send_fraction(0, 7);
        send_fraction(0, 2);
        send_fraction(0, MOST_POS);
    endtask

    task automatic test_pass_through();
        send_fraction(5, 1);
        send_fraction(-5, 1);
        send_fraction(3, 0);
        send_fraction(0, 0);
        send_fraction(6, -4);
        send_fraction(1, MOST_NEG);
        send_fraction(MOST_NEG, -1);
        send_fraction(MOST_POS, '1);
    endtask

    task automatic test_most_negative();
        send_fraction(MOST_NEG, 3);
        send_fraction(MOST_NEG, MOST_POS);
        send_fraction(MOST_NEG, 2);
        send_fraction(MOST_NEG, 1024);
    endtask

    task automatic test_reduction();
        send_fraction(6, 4);
        send_fraction(-6, 4);
        send_fraction(12, 18);
        send_fraction(MOST_POS, MOST_POS);
        // consecutive fibonacci numbers give the longest euclid chain
        send_fraction(1836311903, 1134903170);
        send_fraction(-1, MOST_POS);
        send_fraction(100, 10);
    endtask

    task automatic test_random_fractions();
        logic [WORD_BITS-1:0] n;
        logic [WORD_BITS-1:0] d;
        logic [WORD_BITS-1:0] g;
        int unsigned          pick;
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                n = $urandom;
                case ($urandom_range(0, 2))
                    0:       d = 0;
                    1:       d = 1;
                    default: d = $urandom | MOST_NEG;
                endcase
            end
            else if (pick < 5)
            begin
                n = $urandom;
                d = $urandom & MOST_POS;
            end
            else if (pick < 8)
            begin
                // shared factor so the division usually shrinks both parts
                g = $urandom_range(1, 1000);
                n = $urandom_range(0, 32768) * g;
                d = $urandom_range(2, 32768) * g;
                if ($urandom_range(0, 1))
                    n = -n;
            end
            else
            begin
                n = $urandom_range(0, 510) - 255;
                d = $urandom_range(0, 64);
            end
            send_fraction(n, d);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        feed_if.valid = 1'b0;
        feed_if.numer_in = '0;
        feed_if.denom_in = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_numerator();
        test_pass_through();
        test_most_negative();
        test_reduction();
        test_random_fractions();
        feed_if.valid <= 1'b0;

        while (pending_terms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
